@@ rtl/dcbp_pkg.sv @@
package dcbp_pkg;

    // Width of the speed number and its saturation limit
    localparam int SPEED_WIDTH = 16;
    localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = {SPEED_WIDTH{1'b1}};

    // Stream word widths, fields packed from bit 0 and padded to bytes
    localparam int BYTE_W     = 8;
    localparam int TAG_W      = 4;
    localparam int CODE_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int IN_BITS    = BYTE_W + TAG_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = CODE_W + SPEED_WIDTH + TAG_W + STATUS_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // Queue between decoder and result sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CODE_W-1:0] {
        CMD_FWD   = 4'd0,
        CMD_BACK  = 4'd1,
        CMD_LEFT  = 4'd2,
        CMD_RIGHT = 4'd3,
        CMD_STOP  = 4'd4,
        CMD_SPEED = 4'd5,
        CMD_SONAR = 4'd6,
        CMD_TELEM = 4'd7,
        CMD_END   = 4'd8
    } cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        END_NORMAL = 2'd0,
        END_HANGUP = 2'd1,
        END_QUIT   = 2'd2
    } end_status_t;

    // All results caused by one byte, in emission order: speed, command, chunk end
    typedef struct packed {
        logic                   speed_vld;
        logic [SPEED_WIDTH-1:0] speed_val;
        logic                   cmd_vld;
        cmd_code_t              cmd;
        logic [TAG_W-1:0]       tag;
        logic                   end_vld;
        end_status_t            status;
    } entry_t;

endpackage

@@ rtl/dcbp_front.sv @@
module dcbp_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcbp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] byte_value, [11:8] client_tag
    input  logic                           s_tlast,
    input  logic                           full_i,
    output logic                           push_o,
    output dcbp_pkg::entry_t               entry_o
);
    import dcbp_pkg::*;

    localparam int ACC_W = SPEED_WIDTH + 4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_Z     = 8'h7a;

    logic                   fb_en_reg,      fb_en_next;
    logic                   turn_en_reg,    turn_en_next;
    logic                   in_num_reg,     in_num_next;
    logic                   digit_seen_reg, digit_seen_next;
    logic [SPEED_WIDTH-1:0] accum_reg,      accum_next;
    end_status_t            halted_reg,     halted_next;

    logic [BYTE_W-1:0] byte_val;
    logic [TAG_W-1:0]  tag_val;
    logic [7:0]        lc;
    logic              is_digit;
    logic              is_letter;
    logic              accept;
    logic [ACC_W-1:0]  acc_ext;
    logic [ACC_W-1:0]  times_ten;
    logic [SPEED_WIDTH-1:0] acc_sat;
    entry_t            ent;

    assign byte_val  = s_tdata[BYTE_W-1:0];
    assign tag_val   = s_tdata[BYTE_W +: TAG_W];
    assign lc        = byte_val | CH_SPACE;
    assign is_digit  = (byte_val >= CH_ZERO) && (byte_val <= CH_NINE);
    assign is_letter = ((byte_val >= CH_UA) && (byte_val <= CH_UZ)) ||
                       ((byte_val >= CH_LA) && (byte_val <= CH_LZ));
    assign s_tready  = !full_i;
    assign accept    = s_tvalid && s_tready;

    // Multiply by ten, add the digit, saturate
    assign acc_ext   = {{(ACC_W-SPEED_WIDTH){1'b0}}, accum_reg};
    assign times_ten = (acc_ext << 3) + (acc_ext << 1) +
                       {{(ACC_W-4){1'b0}}, byte_val[3:0]};
    assign acc_sat   = (times_ten > {{(ACC_W-SPEED_WIDTH){1'b0}}, SPEED_MAX}) ?
                       SPEED_MAX : times_ten[SPEED_WIDTH-1:0];

    // Decode one byte into its results and the next parser state
    always_comb begin
        logic decode;
        decode          = 1'b1;
        fb_en_next      = fb_en_reg;
        turn_en_next    = turn_en_reg;
        in_num_next     = in_num_reg;
        digit_seen_next = digit_seen_reg;
        accum_next      = accum_reg;
        halted_next     = halted_reg;
        ent             = '0;
        ent.cmd         = CMD_STOP;
        ent.status      = END_NORMAL;

        // Close or extend an open number
        if (halted_reg != END_NORMAL) begin
            decode = 1'b0;
        end else if (in_num_reg) begin
            if (is_digit) begin
                accum_next      = acc_sat;
                digit_seen_next = 1'b1;
                decode          = 1'b0;
                if (s_tlast) begin
                    ent.speed_vld = 1'b1;
                    ent.speed_val = acc_sat;
                    in_num_next   = 1'b0;
                end
            end else begin
                if (digit_seen_reg) begin
                    ent.speed_vld = 1'b1;
                    ent.speed_val = accum_reg;
                end
                in_num_next = 1'b0;
            end
        end

        // Decode the byte's own command
        if (decode) begin
            if (byte_val == CH_SPACE) begin
                ent.cmd_vld = 1'b1;
                ent.cmd     = CMD_STOP;
            end else if (is_letter) begin
                unique case (lc)
                    CH_F: begin
                        ent.cmd_vld = fb_en_reg;
                        ent.cmd     = CMD_FWD;
                    end
                    CH_B: begin
                        ent.cmd_vld = fb_en_reg;
                        ent.cmd     = CMD_BACK;
                    end
                    CH_L: begin
                        ent.cmd_vld = turn_en_reg;
                        ent.cmd     = CMD_LEFT;
                    end
                    CH_R: begin
                        ent.cmd_vld = turn_en_reg;
                        ent.cmd     = CMD_RIGHT;
                    end
                    CH_S: begin
                        if (!s_tlast) begin
                            in_num_next     = 1'b1;
                            digit_seen_next = 1'b0;
                            accum_next      = '0;
                        end
                    end
                    CH_P: begin
                        ent.cmd_vld = 1'b1;
                        ent.cmd     = CMD_SONAR;
                    end
                    CH_T: begin
                        ent.cmd_vld = 1'b1;
                        ent.cmd     = CMD_TELEM;
                        ent.tag     = tag_val;
                    end
                    CH_X: begin
                        ent.cmd_vld = 1'b1;
                        ent.cmd     = CMD_STOP;
                        fb_en_next  = 1'b0;
                    end
                    CH_W: fb_en_next = 1'b1;
                    CH_Z: begin
                        ent.cmd_vld  = 1'b1;
                        ent.cmd      = CMD_STOP;
                        turn_en_next = 1'b0;
                    end
                    CH_Y: turn_en_next = 1'b1;
                    CH_D, CH_Q: begin
                        ent.cmd_vld  = 1'b1;
                        ent.cmd      = CMD_STOP;
                        fb_en_next   = 1'b0;
                        turn_en_next = 1'b0;
                        halted_next  = (lc == CH_D) ? END_HANGUP : END_QUIT;
                    end
                    default: ;
                endcase
            end
        end

        // Mark the chunk end and clear per-chunk state
        if (s_tlast) begin
            ent.end_vld     = 1'b1;
            ent.status      = halted_next;
            halted_next     = END_NORMAL;
            in_num_next     = 1'b0;
            digit_seen_next = 1'b0;
            accum_next      = '0;
        end
    end

    assign entry_o = ent;
    assign push_o  = accept && (ent.speed_vld || ent.cmd_vld || ent.end_vld);

    // Advance parser state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_en_reg      <= 1'b0;
            turn_en_reg    <= 1'b0;
            in_num_reg     <= 1'b0;
            digit_seen_reg <= 1'b0;
            accum_reg      <= '0;
            halted_reg     <= END_NORMAL;
        end else if (accept) begin
            fb_en_reg      <= fb_en_next;
            turn_en_reg    <= turn_en_next;
            in_num_reg     <= in_num_next;
            digit_seen_reg <= digit_seen_next;
            accum_reg      <= accum_next;
            halted_reg     <= halted_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (halted_reg == END_NORMAL) && !in_num_reg && !digit_seen_reg)
        else $error("chunk end did not clear per-chunk state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_num_reg && is_digit && !s_tlast && (halted_reg == END_NORMAL))
        |-> !push_o)
        else $error("digit inside a number produced a result");
`endif

endmodule

@@ rtl/dcbp_queue.sv @@
module dcbp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_i,
    input  dcbp_pkg::entry_t entry_i,
    input  logic             pop_i,
    output dcbp_pkg::entry_t head_o,
    output logic             full_o,
    output logic             empty_o
);
    import dcbp_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg,  count_next;

    assign full_o  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty_o = (count_reg == '0);
    assign head_o  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop_i) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push_i && !pop_i) begin
            count_next = count_reg + 1'b1;
        end else if (pop_i && !push_i) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push_i) begin
            slot_reg[wr_ptr_reg] <= entry_i;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop_i |-> !empty_o)
        else $error("pop from empty queue");
`endif

endmodule

@@ rtl/dcbp_back.sv @@
module dcbp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dcbp_pkg::entry_t               head_i,
    input  logic                           empty_i,
    output logic                           pop_o,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] cmd_code, [19:4] speed_value, [23:20] reply_tag, [25:24] end_status
    output logic [dcbp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import dcbp_pkg::*;

    // Result slots of an entry: bit 0 speed, bit 1 command, bit 2 chunk end
    logic [2:0]             done_reg, done_next;
    logic                   valid_reg, valid_next;
    cmd_code_t              code_reg;
    logic [SPEED_WIDTH-1:0] speed_reg;
    logic [TAG_W-1:0]       tag_reg;
    end_status_t            status_reg;
    logic                   last_reg;

    logic [2:0]             flags;
    logic [2:0]             remain;
    logic [2:0]             sel;
    logic                   load;
    logic                   is_last;
    cmd_code_t              code_d;
    logic [SPEED_WIDTH-1:0] speed_d;
    logic [TAG_W-1:0]       tag_d;
    end_status_t            status_d;

    assign flags   = {head_i.end_vld, head_i.cmd_vld, head_i.speed_vld};
    assign remain  = flags & ~done_reg;
    assign load    = !empty_i && (!valid_reg || m_tready);
    assign is_last = ((remain & ~sel) == '0);
    assign pop_o   = load && is_last;

    // Pick the earliest result still pending in the head entry
    always_comb begin
        sel      = '0;
        code_d   = CMD_END;
        speed_d  = '0;
        tag_d    = '0;
        status_d = END_NORMAL;
        priority if (remain[0]) begin
            sel     = 3'b001;
            code_d  = CMD_SPEED;
            speed_d = head_i.speed_val;
        end else if (remain[1]) begin
            sel    = 3'b010;
            code_d = head_i.cmd;
            tag_d  = head_i.tag;
        end else begin
            sel      = 3'b100;
            code_d   = CMD_END;
            status_d = head_i.status;
        end
    end

    // Track emitted slots and output valid
    always_comb begin
        done_next  = done_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            done_next  = is_last ? 3'b000 : (done_reg | sel);
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg   <= code_d;
            speed_reg  <= speed_d;
            tag_reg    <= tag_d;
            status_reg <= status_d;
            last_reg   <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_BITS){1'b0}}, status_reg, tag_reg, speed_reg, code_reg};

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        !empty_i |-> ((done_reg & ~flags) == 3'b000))
        else $error("emitted slot not present in head entry");
`endif

endmodule

@@ rtl/drive_command_byte_parser_core.sv @@
// Drive command byte parser.
// Input stream (s_): one received byte per word; s_tdata[7:0] is the byte,
// s_tdata[11:8] the client tag, s_tlast marks the last byte of a chunk.
// Output stream (m_): one result per word; m_tdata carries cmd_code, speed
// value, reply tag and end status, m_tlast marks the final result of a byte.
// A byte gives zero to three results: a closed speed number, its own command
// and, on the last byte of a chunk, a chunk-end marker with its status.
// A byte's results are written into the queue and then loaded into the
// output register. The input takes one byte per cycle while the queue is
// not full; a byte with several results holds the output for one word each,
// and bytes without results produce no output word.
// A four-entry queue sits between the decoder and the output sequencer,
// so the input keeps taking bytes while the output waits; s_tready drops
// only when that queue is full.
// Reset (aresetn low, synchronous) disables both motion axes, clears any
// open number or halted chunk and empties the queue and output register.
module drive_command_byte_parser_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcbp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] byte_value, [11:8] client_tag
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] cmd_code, [19:4] speed_value, [23:20] reply_tag, [25:24] end_status
    output logic [dcbp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import dcbp_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    entry_t push_entry;
    entry_t head_entry;

    dcbp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .full_i   (full),
        .push_o   (push),
        .entry_o  (push_entry)
    );

    dcbp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .entry_i (push_entry),
        .pop_i   (pop),
        .head_o  (head_entry),
        .full_o  (full),
        .empty_o (empty)
    );

    dcbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_i   (head_entry),
        .empty_i  (empty),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/drive_command_byte_parser_core_tb.sv @@
module drive_command_byte_parser_core_tb;
    import dcbp_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 250;
    localparam int IDLE_PCT    = 17;
    localparam int DRAIN_CYCLES = 16;

    // Command letters, matched in lower case
    localparam logic [7:0] KEY_FWD      = "f";
    localparam logic [7:0] KEY_BACK     = "b";
    localparam logic [7:0] KEY_LEFT     = "l";
    localparam logic [7:0] KEY_RIGHT    = "r";
    localparam logic [7:0] KEY_SPEED    = "s";
    localparam logic [7:0] KEY_SONAR    = "p";
    localparam logic [7:0] KEY_TELEM    = "t";
    localparam logic [7:0] KEY_FB_OFF   = "x";
    localparam logic [7:0] KEY_FB_ON    = "w";
    localparam logic [7:0] KEY_TURN_OFF = "z";
    localparam logic [7:0] KEY_TURN_ON  = "y";
    localparam logic [7:0] KEY_HANGUP   = "d";
    localparam logic [7:0] KEY_QUIT     = "q";
    localparam logic [7:0] KEY_SOCKET   = "e";
    localparam logic [7:0] KEY_SPACE    = 8'd32;
    localparam logic [7:0] CASE_BIT     = 8'h20;
    localparam logic [7:0] LETTER_A     = "a";
    localparam logic [7:0] LETTER_Z     = "z";
    localparam logic [7:0] DIGIT_0      = "0";
    localparam logic [7:0] DIGIT_9      = "9";

    typedef struct packed {
        cmd_code_t              code;
        logic [SPEED_WIDTH-1:0] speed;
        logic [TAG_W-1:0]       tag;
        end_status_t            status;
        logic                   last;
    } drive_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Parser state as predicted
    logic                 fwd_back_on      = 1'b0;
    logic                 turn_on          = 1'b0;
    logic                 number_open      = 1'b0;
    logic                 number_has_digit = 1'b0;
    int unsigned          speed_accum      = 0;
    end_status_t          chunk_halt       = END_NORMAL;

    drive_result_t        expected_cmds[$];
    drive_result_t        seen_result;
    drive_result_t        want_result;
    int                   errors       = 0;
    int                   cycle_cnt    = 0;
    bit                   idle_on      = 1'b1;
    int                   hold_req_cnt = 0;
    int                   hold_ack_cnt = 0;
    int                   hold_left    = 0;

    drive_command_byte_parser_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("drive_command_byte_parser_core_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (idle_on) begin
            m_tready <= ($urandom_range(99, 0) >= IDLE_PCT);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each output word with the oldest expected command
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.code   = cmd_code_t'(m_tdata[CODE_W-1:0]);
            seen_result.speed  = m_tdata[CODE_W +: SPEED_WIDTH];
            seen_result.tag    = m_tdata[CODE_W+SPEED_WIDTH +: TAG_W];
            seen_result.status = end_status_t'(m_tdata[CODE_W+SPEED_WIDTH+TAG_W +: STATUS_W]);
            seen_result.last   = m_tlast;
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: code %0d speed %0d tag %0d status %0d last %0b",
                         $time, seen_result.code, seen_result.speed, seen_result.tag,
                         seen_result.status, seen_result.last);
            end else begin
                want_result = expected_cmds.pop_front();
                if (seen_result !== want_result) begin
                    errors++;
                    $display("%0t: mismatch: expected code %0d speed %0d tag %0d status %0d last %0b",
                             $time, want_result.code, want_result.speed, want_result.tag,
                             want_result.status, want_result.last);
                    $display("%0t:           actual code %0d speed %0d tag %0d status %0d last %0b",
                             $time, seen_result.code, seen_result.speed, seen_result.tag,
                             seen_result.status, seen_result.last);
                end
            end
        end
    end

    function automatic drive_result_t make_result(input cmd_code_t code,
                                                  input logic [SPEED_WIDTH-1:0] speed,
                                                  input logic [TAG_W-1:0] tag,
                                                  input end_status_t status);
        drive_result_t r;
        r.code   = code;
        r.speed  = speed;
        r.tag    = tag;
        r.status = status;
        r.last   = 1'b0;
        return r;
    endfunction

    // Decode one accepted byte and queue the commands it should produce
    task automatic predict_commands(input logic [7:0] b, input logic lst,
                                    input logic [TAG_W-1:0] tag);
        drive_result_t res [3];
        int            n;
        logic          run_decode;
        logic [7:0]    lc;
        logic          is_digit;
        n          = 0;
        run_decode = 1'b1;
        lc         = b | CASE_BIT;
        is_digit   = (b >= DIGIT_0) && (b <= DIGIT_9);

        // Halted chunk swallows everything; an open number eats digits
        if (chunk_halt != END_NORMAL) begin
            run_decode = 1'b0;
        end else if (number_open) begin
            if (is_digit) begin
                speed_accum = speed_accum * 10 + 32'(b - DIGIT_0);
                if (speed_accum > 32'(SPEED_MAX))
                    speed_accum = 32'(SPEED_MAX);
                number_has_digit = 1'b1;
                run_decode       = 1'b0;
                if (lst) begin
                    res[n] = make_result(CMD_SPEED, speed_accum[SPEED_WIDTH-1:0], '0, END_NORMAL);
                    n++;
                    number_open = 1'b0;
                end
            end else begin
                if (number_has_digit) begin
                    res[n] = make_result(CMD_SPEED, speed_accum[SPEED_WIDTH-1:0], '0, END_NORMAL);
                    n++;
                end
                number_open = 1'b0;
            end
        end

        // Decode the byte as a command
        if (run_decode) begin
            if (b == KEY_SPACE) begin
                res[n] = make_result(CMD_STOP, '0, '0, END_NORMAL);
                n++;
            end else if (lc >= LETTER_A && lc <= LETTER_Z) begin
                case (lc)
                    KEY_FWD: if (fwd_back_on) begin
                        res[n] = make_result(CMD_FWD, '0, '0, END_NORMAL);
                        n++;
                    end
                    KEY_BACK: if (fwd_back_on) begin
                        res[n] = make_result(CMD_BACK, '0, '0, END_NORMAL);
                        n++;
                    end
                    KEY_LEFT: if (turn_on) begin
                        res[n] = make_result(CMD_LEFT, '0, '0, END_NORMAL);
                        n++;
                    end
                    KEY_RIGHT: if (turn_on) begin
                        res[n] = make_result(CMD_RIGHT, '0, '0, END_NORMAL);
                        n++;
                    end
                    KEY_SPEED: if (!lst) begin
                        number_open      = 1'b1;
                        number_has_digit = 1'b0;
                        speed_accum      = 0;
                    end
                    KEY_SONAR: begin
                        res[n] = make_result(CMD_SONAR, '0, '0, END_NORMAL);
                        n++;
                    end
                    KEY_TELEM: begin
                        res[n] = make_result(CMD_TELEM, '0, tag, END_NORMAL);
                        n++;
                    end
                    KEY_FB_OFF: begin
                        res[n] = make_result(CMD_STOP, '0, '0, END_NORMAL);
                        n++;
                        fwd_back_on = 1'b0;
                    end
                    KEY_FB_ON: fwd_back_on = 1'b1;
                    KEY_TURN_OFF: begin
                        res[n] = make_result(CMD_STOP, '0, '0, END_NORMAL);
                        n++;
                        turn_on = 1'b0;
                    end
                    KEY_TURN_ON: turn_on = 1'b1;
                    KEY_HANGUP, KEY_QUIT: begin
                        res[n] = make_result(CMD_STOP, '0, '0, END_NORMAL);
                        n++;
                        fwd_back_on = 1'b0;
                        turn_on     = 1'b0;
                        chunk_halt  = (lc == KEY_HANGUP) ? END_HANGUP : END_QUIT;
                    end
                    default: ;
                endcase
            end
        end

        // Close the chunk
        if (lst) begin
            res[n] = make_result(CMD_END, '0, '0, chunk_halt);
            n++;
            chunk_halt       = END_NORMAL;
            number_open      = 1'b0;
            number_has_digit = 1'b0;
            speed_accum      = 0;
        end

        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            expected_cmds.push_back(res[i]);
        end
    endtask

    // Offer one byte, idling at random first; predict once it is taken
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [TAG_W-1:0] tag);
        while (idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({tag, b});
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_commands(b, lst, tag);
    endtask

    task automatic send_text(input string text, input logic [TAG_W-1:0] tag, input bit close);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], close && (i == text.len() - 1), tag);
    endtask

    function automatic logic [7:0] random_byte(input logic in_digits);
        int unsigned roll;
        logic [7:0]  key;
        roll = $urandom_range(99, 0);
        if (in_digits && roll < 65)
            return 8'(DIGIT_0 + $urandom_range(9, 0));
        if (roll >= 90)
            return 8'($urandom_range(255, 0));
        if (roll >= 85)
            return 8'(DIGIT_0 + $urandom_range(9, 0));
        if (roll >= 82)
            key = $urandom_range(1, 0) ? KEY_HANGUP : KEY_QUIT;
        else begin
            case ($urandom_range(12, 0))
                0:       key = KEY_FWD;
                1:       key = KEY_BACK;
                2:       key = KEY_LEFT;
                3:       key = KEY_RIGHT;
                4:       key = KEY_SPEED;
                5:       key = KEY_SONAR;
                6:       key = KEY_TELEM;
                7:       key = KEY_FB_OFF;
                8:       key = KEY_FB_ON;
                9:       key = KEY_TURN_OFF;
                10:      key = KEY_TURN_ON;
                11:      key = KEY_SOCKET;
                default: key = KEY_SPACE;
            endcase
        end
        // Flip to upper case half the time
        if (key != KEY_SPACE && $urandom_range(1, 0))
            key = key & ~CASE_BIT;
        return key;
    endfunction

    // Gating of both axes, the command letters other than s, d and q, odd bytes
    task automatic test_motion_gating();
        send_text("fwFbLylR pte", 4'h0, 1'b0);
        send_byte(8'hFF, 1'b0, 4'hF);
        send_byte(8'h00, 1'b0, 4'h0);
        send_text("xBzrT", 4'hF, 1'b1);
    endtask

    // Number closed by a byte, empty number, saturation, number at chunk end
    task automatic test_speed_numbers();
        send_text("s127 sa", 4'h5, 1'b0);
        send_text("S70000", 4'hA, 1'b1);
        send_text("s", 4'h3, 1'b1);
    endtask

    // Hang-up with the rest of the chunk ignored, then quit on the last byte
    task automatic test_chunk_halts();
        send_text("wdfs5", 4'h6, 1'b1);
        send_text("Q", 4'h9, 1'b1);
    endtask

    // Random chunks, mostly well-formed commands and numbers
    task automatic test_random_chunks(input int n_bytes);
        int               sent;
        int               len;
        logic [TAG_W-1:0] tag;
        logic [7:0]       b;
        logic             in_digits;
        sent = 0;
        while (sent < n_bytes) begin
            len       = $urandom_range(10, 1);
            tag       = TAG_W'($urandom_range(15, 0));
            in_digits = 1'b0;
            for (int i = 0; i < len; i++) begin
                b = random_byte(in_digits);
                in_digits = ((b | CASE_BIT) == KEY_SPEED)
                            || (in_digits && b >= DIGIT_0 && b <= DIGIT_9);
                send_byte(b, i == len - 1, tag);
            end
            sent += len;
        end
    endtask

    // Hold the output off while the sender keeps offering result bytes
    task automatic test_backpressure();
        logic [7:0] b;
        hold_req_cnt++;
        for (int i = 0; i < 30; i++) begin
            case ($urandom_range(2, 0))
                0:       b = KEY_SPACE;
                1:       b = KEY_SONAR;
                default: b = KEY_TELEM;
            endcase
            send_byte(b, (i % 8) == 7, TAG_W'($urandom_range(15, 0)));
        end
    endtask

    // Steady stream with no idling on either side
    task automatic test_no_idle();
        idle_on = 1'b0;
        test_random_chunks(60);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_motion_gating();
        test_speed_numbers();
        test_chunk_halts();
        test_backpressure();
        test_random_chunks(170);
        test_no_idle();

        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("drive_command_byte_parser_core_tb OK");
        else
            $display("drive_command_byte_parser_core_tb NOT OK");
        $finish;
    end

endmodule
